>>> sv/sacwp_pkg.sv
// Shared constants and types for the sync/address/count word parser.
// No dependencies; compile first.
package sacwp_pkg;

    localparam logic [7:0]  SYNC_BYTE    = 8'h55;
    localparam logic [15:0] SYNC_ADDRESS = 16'h5555;
    localparam logic [15:0] END_ADDRESS  = 16'hFFFE;
    localparam logic [1:0]  SYNC_RUN_MAX = 2'd3;

    typedef struct packed {
        logic [15:0] word_address;
        logic [15:0] word_value;
        logic        frame_end;
    } word_t;

endpackage

>>> sv/sacwp_if.sv
// Valid/ready channel interfaces for the parser: byte input and word output.
// No dependencies.
interface sacwp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface sacwp_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_address;
    logic [15:0] word_value;
    logic        frame_end;

    modport source (output valid, output word_address, output word_value,
                    output frame_end, input ready);
    modport sink   (input valid, input word_address, input word_value,
                    input frame_end, output ready);
endinterface

>>> sv/sacwp_out_buf.sv
// Two-entry result register with skid stage for the parser word output.
// Depends on sacwp_pkg and sacwp_if.
module sacwp_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sacwp_pkg::word_t     push_word,
    output logic                 space,
    sacwp_word_if.source         words
);
    import sacwp_pkg::*;

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    word_t main_reg, main_next;
    word_t skid_reg, skid_next;
    logic  pop;

    assign pop   = words.valid && words.ready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                // advance the skid entry; input is stalled so nothing new arrives
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_word;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            // hold the waiting word, park the new one
            skid_next       = push_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign words.valid        = main_valid_reg;
    assign words.word_address = main_reg.word_address;
    assign words.word_value   = main_reg.word_value;
    assign words.frame_end    = main_reg.frame_end;

endmodule

>>> sv/sync_address_count_word_parser.sv
// Byte-stream parser: sync run, little-endian address and count, then data words.
// A finished word is registered in the output buffer (main or skid entry) before it is shown.
// Throughput: one byte per cycle while the output buffer has space;
// the skid stage keeps input open while one finished word waits.
// Reset (rst_n low, asynchronous): waits for sync, counters and address cleared,
// output empty.
module sync_address_count_word_parser
(
    input  logic         clk,
    input  logic         rst_n,
    sacwp_byte_if.sink   bytes,
    sacwp_word_if.source words
);
    import sacwp_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT_SYNC = 3'd0,
        PH_ADDR_LO   = 3'd1,
        PH_ADDR_HI   = 3'd2,
        PH_CNT_LO    = 3'd3,
        PH_CNT_HI    = 3'd4,
        PH_DATA_LO   = 3'd5,
        PH_DATA_HI   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  sync_run_reg, sync_run_next;
    logic [15:0] address_reg, address_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  low_byte_reg, low_byte_next;

    logic        space;
    logic        take;
    logic        emit;
    word_t       emit_word;
    logic [7:0]  b;
    logic [15:0] left_dec;

    assign bytes.ready = space;
    assign take        = bytes.valid && space;
    assign b           = bytes.stream_byte;
    assign left_dec    = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        sync_run_next   = sync_run_reg;
        address_next    = address_reg;
        bytes_left_next = bytes_left_reg;
        low_byte_next   = low_byte_reg;
        emit            = 1'b0;
        emit_word.word_address = address_reg;
        emit_word.word_value   = {b, low_byte_reg};
        emit_word.frame_end    = (left_dec == 16'd0) && (address_reg == END_ADDRESS);

        if (take)
        begin
            case (phase_reg)
                PH_ADDR_LO:
                begin
                    address_next = {8'd0, b};
                    phase_next   = PH_ADDR_HI;
                end
                PH_ADDR_HI:
                begin
                    address_next = {b, address_reg[7:0]};
                    phase_next   = ({b, address_reg[7:0]} == SYNC_ADDRESS) ? PH_WAIT_SYNC
                                                                           : PH_CNT_LO;
                end
                PH_CNT_LO:
                begin
                    bytes_left_next = {8'd0, b};
                    phase_next      = PH_CNT_HI;
                end
                PH_CNT_HI:
                begin
                    bytes_left_next = {b, bytes_left_reg[7:0]};
                    phase_next      = PH_DATA_LO;
                end
                PH_DATA_LO:
                begin
                    low_byte_next   = b;
                    bytes_left_next = left_dec;
                    phase_next      = PH_DATA_HI;
                end
                PH_DATA_HI:
                begin
                    emit            = 1'b1;
                    bytes_left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        phase_next = PH_ADDR_LO;
                    end
                    else
                    begin
                        address_next = address_reg + 16'd2;
                        phase_next   = PH_DATA_LO;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT_SYNC;
                end
            endcase

            // fourth sync byte in a row forces a new address, even mid-frame
            if (b == SYNC_BYTE)
            begin
                if (sync_run_reg == SYNC_RUN_MAX)
                begin
                    sync_run_next = 2'd0;
                    phase_next    = PH_ADDR_LO;
                end
                else
                begin
                    sync_run_next = sync_run_reg + 2'd1;
                end
            end
            else
            begin
                sync_run_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_SYNC;
            sync_run_reg   <= 2'd0;
            address_reg    <= 16'd0;
            bytes_left_reg <= 16'd0;
            low_byte_reg   <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            sync_run_reg   <= sync_run_next;
            address_reg    <= address_next;
            bytes_left_reg <= bytes_left_next;
            low_byte_reg   <= low_byte_next;
        end
    end

    sacwp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_word (emit_word),
        .space     (space),
        .words     (words)
    );

endmodule
